[rtl/aet_pkg.sv]
// Shared definitions for the arithmetic expression tokenizer.
// Token kinds, character codes, default widths and the result control struct.
// No dependencies.
`default_nettype none

package aet_pkg;

	localparam int VALUE_BITS_DEF  = 32;
	localparam int LINE_BITS_DEF   = 24;
	localparam int COLUMN_BITS_DEF = 16;

	typedef enum logic [2:0] {
		KIND_END     = 3'd0,
		KIND_ADD     = 3'd1,
		KIND_SUB     = 3'd2,
		KIND_MULT    = 3'd3,
		KIND_DIV     = 3'd4,
		KIND_INTLIT  = 3'd5,
		KIND_INVALID = 3'd6
	} kind_t;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// One queue entry: an optional literal ahead of a single token.
	typedef struct packed {
		logic  has_lit;
		logic  ovf;
		kind_t kind;
	} res_ctrl_t;

endpackage

`default_nettype wire

[rtl/aet_scan.sv]
// Scanner stage: input register, literal accumulator and position counters.
// Produces at most one queue entry per byte. Depends on aet_pkg.
`default_nettype none

module aet_scan #(
	parameter int VALUE_BITS  = aet_pkg::VALUE_BITS_DEF,
	parameter int LINE_BITS   = aet_pkg::LINE_BITS_DEF,
	parameter int COLUMN_BITS = aet_pkg::COLUMN_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [7:0]             ch,
	input  wire logic                   end_of_input,
	input  wire logic                   go,
	output logic                        push,
	output aet_pkg::res_ctrl_t          res_ctrl,
	output logic [VALUE_BITS-1:0]       res_value,
	output logic [LINE_BITS-1:0]        res_line,
	output logic [COLUMN_BITS-1:0]      res_col
);

	localparam int PW = VALUE_BITS + 4;

	logic                   valid_s1;
	logic [7:0]             ch_s1;
	logic                   end_s1;

	logic                   in_lit_q;
	logic [VALUE_BITS-1:0]  acc_q;
	logic                   ovf_q;
	logic [LINE_BITS-1:0]   line_q;
	logic [COLUMN_BITS-1:0] col_q;

	logic                   in_lit_d;
	logic [VALUE_BITS-1:0]  acc_d;
	logic                   ovf_d;
	logic [LINE_BITS-1:0]   line_d;
	logic [COLUMN_BITS-1:0] col_d;

	logic                   consume;
	logic                   has_res;
	logic                   is_ws;
	logic                   is_num;
	logic [3:0]             digit;
	logic [PW-1:0]          prod;
	logic                   prod_ovf;
	aet_pkg::kind_t         tok_kind;

	assign in_stall = valid_s1 & ~go;
	assign consume  = valid_s1 & go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			ch_s1  <= ch;
			end_s1 <= end_of_input;
		end
	end

	always_comb begin
		is_ws    = ch_s1 inside {aet_pkg::CH_SPACE, aet_pkg::CH_TAB, aet_pkg::CH_LF,
			aet_pkg::CH_CR, aet_pkg::CH_FF};
		is_num   = ch_s1 inside {[aet_pkg::CH_ZERO:aet_pkg::CH_NINE]};
		digit    = 4'(ch_s1 - aet_pkg::CH_ZERO);
		prod     = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + PW'(digit);
		prod_ovf = |prod[PW-1:VALUE_BITS];

		case (ch_s1)
			aet_pkg::CH_PLUS:  tok_kind = aet_pkg::KIND_ADD;
			aet_pkg::CH_MINUS: tok_kind = aet_pkg::KIND_SUB;
			aet_pkg::CH_STAR:  tok_kind = aet_pkg::KIND_MULT;
			aet_pkg::CH_SLASH: tok_kind = aet_pkg::KIND_DIV;
			default:           tok_kind = aet_pkg::KIND_INVALID;
		endcase

		in_lit_d = in_lit_q;
		acc_d    = acc_q;
		ovf_d    = ovf_q;
		line_d   = line_q;
		col_d    = col_q;
		has_res  = 1'b0;
		res_ctrl = '{has_lit: in_lit_q, ovf: ovf_q, kind: tok_kind};

		if (end_s1) begin
			has_res       = 1'b1;
			res_ctrl.kind = aet_pkg::KIND_END;
			in_lit_d      = 1'b0;
			acc_d         = '0;
			ovf_d         = 1'b0;
		end else begin
			if (ch_s1 == aet_pkg::CH_LF) begin
				if (line_q != '1) begin
					line_d = line_q + LINE_BITS'(1);
				end
				col_d = COLUMN_BITS'(1);
			end else if (col_q != '1) begin
				col_d = col_q + COLUMN_BITS'(1);
			end

			if (is_ws) begin
				has_res = 1'b0;
			end else if (is_num) begin
				if (!in_lit_q) begin
					in_lit_d = 1'b1;
					acc_d    = VALUE_BITS'(digit);
					ovf_d    = 1'b0;
				end else if (ovf_q || prod_ovf) begin
					acc_d = '1;
					ovf_d = 1'b1;
				end else begin
					acc_d = prod[VALUE_BITS-1:0];
				end
			end else begin
				has_res  = 1'b1;
				in_lit_d = 1'b0;
				acc_d    = '0;
				ovf_d    = 1'b0;
			end
		end
	end

	assign push      = consume & has_res;
	assign res_value = acc_q;
	assign res_line  = line_d;
	assign res_col   = col_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_lit_q <= 1'b0;
			acc_q    <= '0;
			ovf_q    <= 1'b0;
			line_q   <= LINE_BITS'(1);
			col_q    <= COLUMN_BITS'(1);
		end else if (consume) begin
			in_lit_q <= in_lit_d;
			acc_q    <= acc_d;
			ovf_q    <= ovf_d;
			line_q   <= line_d;
			col_q    <= col_d;
		end
	end

`ifndef SYNTHESIS
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty stage");
	a_pos_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		line_q != '0 && col_q != '0)
		else $error("position counter reached zero");
	a_ovf_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (in_lit_q && acc_q == '1))
		else $error("overflow flag without saturated literal");
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(consume && end_s1) |=> !in_lit_q)
		else $error("literal still open after end mark");
`endif

endmodule

`default_nettype wire

[rtl/aet_outq.sv]
// Result queue: two entries, each an optional literal followed by one token.
// Presents the literal then the token on the output channel. Depends on aet_pkg.
`default_nettype none

module aet_outq #(
	parameter int VALUE_BITS  = aet_pkg::VALUE_BITS_DEF,
	parameter int LINE_BITS   = aet_pkg::LINE_BITS_DEF,
	parameter int COLUMN_BITS = aet_pkg::COLUMN_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	input  wire aet_pkg::res_ctrl_t            res_ctrl,
	input  wire logic [VALUE_BITS-1:0]         res_value,
	input  wire logic [LINE_BITS-1:0]          res_line,
	input  wire logic [COLUMN_BITS-1:0]        res_col,
	output logic                               ready,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [2:0]                         token_kind,
	output logic [VALUE_BITS-1:0]              literal_value,
	output logic                               overflowed,
	output logic [LINE_BITS-1:0]               line_at,
	output logic [COLUMN_BITS-1:0]             column_at,
	output logic                               last
);

	aet_pkg::res_ctrl_t     ctrl_q  [2];
	logic [VALUE_BITS-1:0]  value_q [2];
	logic [LINE_BITS-1:0]   line_q  [2];
	logic [COLUMN_BITS-1:0] col_q   [2];

	logic [1:0]             count_q;
	logic                   wr_q;
	logic                   rd_q;
	logic                   sub_q;

	aet_pkg::res_ctrl_t     head;
	logic                   show_lit;
	logic                   out_accept;
	logic                   pop;

	assign head       = ctrl_q[rd_q];
	assign show_lit   = head.has_lit & ~sub_q;
	assign out_valid  = count_q != 2'd0;
	assign out_accept = out_valid & ~out_stall;
	assign pop        = out_accept & ~show_lit;
	assign ready      = count_q != 2'd2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			sub_q   <= 1'b0;
		end else begin
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (out_accept) begin
				sub_q <= show_lit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ctrl_q[wr_q]  <= res_ctrl;
			value_q[wr_q] <= res_value;
			line_q[wr_q]  <= res_line;
			col_q[wr_q]   <= res_col;
		end
	end

	assign token_kind    = show_lit ? aet_pkg::KIND_INTLIT : head.kind;
	assign literal_value = show_lit ? value_q[rd_q] : '0;
	assign overflowed    = show_lit & head.ovf;
	assign line_at       = line_q[rd_q];
	assign column_at     = col_q[rd_q];
	assign last          = ~show_lit;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("result queue over capacity");
	a_sub_has_lit: assert property (@(posedge clk) disable iff (!arst_n)
		sub_q |-> (count_q != 2'd0 && head.has_lit))
		else $error("token phase without a delivered literal");
	a_first_is_lit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last) |-> token_kind == aet_pkg::KIND_INTLIT)
		else $error("non-final result is not a literal");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> ready)
		else $error("push into full queue");
`endif

endmodule

`default_nettype wire

[rtl/arith_expression_tokenizer_unit.sv]
// Top level of the arithmetic expression tokenizer.
// Instantiates aet_scan and aet_outq; depends on aet_pkg.
`default_nettype none

// One source byte (or an end mark) enters per transaction and a new byte can be
// taken every cycle while the result queue has room. The byte is registered,
// scanned and its results written as one entry into a two-entry result queue, so
// the input keeps moving while a result waits. A byte that ends a literal produces
// two results (literal, then its own token); whitespace and digits produce none.
// Sustained rate is one byte per cycle for single-result traffic when out_stall is
// low, set by the output port delivering one result per cycle. Results carry the
// line and column after the byte; last marks the final result of a byte.
module arith_expression_tokenizer_unit #(
	parameter int VALUE_BITS  = aet_pkg::VALUE_BITS_DEF,
	parameter int LINE_BITS   = aet_pkg::LINE_BITS_DEF,
	parameter int COLUMN_BITS = aet_pkg::COLUMN_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [7:0]             ch,
	input  wire logic                   end_of_input,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [2:0]                  token_kind,
	output logic [VALUE_BITS-1:0]       literal_value,
	output logic                        overflowed,
	output logic [LINE_BITS-1:0]        line_at,
	output logic [COLUMN_BITS-1:0]      column_at,
	output logic                        last
);

	logic                   push;
	logic                   ready;
	aet_pkg::res_ctrl_t     res_ctrl;
	logic [VALUE_BITS-1:0]  res_value;
	logic [LINE_BITS-1:0]   res_line;
	logic [COLUMN_BITS-1:0] res_col;

	aet_scan #(
		.VALUE_BITS  (VALUE_BITS),
		.LINE_BITS   (LINE_BITS),
		.COLUMN_BITS (COLUMN_BITS)
	) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.ch           (ch),
		.end_of_input (end_of_input),
		.go           (ready),
		.push         (push),
		.res_ctrl     (res_ctrl),
		.res_value    (res_value),
		.res_line     (res_line),
		.res_col      (res_col)
	);

	aet_outq #(
		.VALUE_BITS  (VALUE_BITS),
		.LINE_BITS   (LINE_BITS),
		.COLUMN_BITS (COLUMN_BITS)
	) u_outq (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.res_ctrl      (res_ctrl),
		.res_value     (res_value),
		.res_line      (res_line),
		.res_col       (res_col),
		.ready         (ready),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.token_kind    (token_kind),
		.literal_value (literal_value),
		.overflowed    (overflowed),
		.line_at       (line_at),
		.column_at     (column_at),
		.last          (last)
	);

endmodule

`default_nettype wire

[bench/arith_expression_tokenizer_unit_tb.sv]
// Self-checking bench for arith_expression_tokenizer_unit: sends source bytes and end marks,
// predicts every token in order and checks each result under random gaps and stalls.
// Depends on aet_pkg and the tokenizer RTL.
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HANG_LIMIT = 2000;
	localparam int VB = aet_pkg::VALUE_BITS_DEF;
	localparam int LB = aet_pkg::LINE_BITS_DEF;
	localparam int CB = aet_pkg::COLUMN_BITS_DEF;

	typedef struct packed {
		aet_pkg::kind_t kind;
		logic [VB-1:0]  value;
		logic           ovf;
		logic [LB-1:0]  line;
		logic [CB-1:0]  col;
		logic           is_last;
	} token_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] ch = '0;
	logic end_of_input = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] token_kind;
	logic [VB-1:0] literal_value;
	logic overflowed;
	logic [LB-1:0] line_at;
	logic [CB-1:0] column_at;
	logic last;

	// scanner state as the block should hold it
	logic in_lit = 1'b0;
	logic [VB-1:0] acc = '0;
	logic acc_ovf = 1'b0;
	logic [LB-1:0] line_no = LB'(1);
	logic [CB-1:0] col_no = CB'(1);

	token_t tokens_due[$];
	logic steady = 1'b0;
	int stall_left = 0;
	int quiet_cycles = 0;
	int bytes_sent = 0;
	int tokens_seen = 0;
	int literals_seen = 0;
	int saturated_seen = 0;
	int mismatches = 0;

	arith_expression_tokenizer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.ch(ch),
		.end_of_input(end_of_input),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.token_kind(token_kind),
		.literal_value(literal_value),
		.overflowed(overflowed),
		.line_at(line_at),
		.column_at(column_at),
		.last(last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int idle_len();
		return ($urandom_range(0, 11) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
	endfunction

	function automatic logic [7:0] any_space();
		case ($urandom_range(0, 4))
			0: return aet_pkg::CH_SPACE;
			1: return aet_pkg::CH_TAB;
			2: return aet_pkg::CH_LF;
			3: return aet_pkg::CH_CR;
			default: return aet_pkg::CH_FF;
		endcase
	endfunction

	function automatic logic [7:0] any_operator();
		case ($urandom_range(0, 3))
			0: return aet_pkg::CH_PLUS;
			1: return aet_pkg::CH_MINUS;
			2: return aet_pkg::CH_STAR;
			default: return aet_pkg::CH_SLASH;
		endcase
	endfunction

	function automatic void tokenize_byte(logic [7:0] b, logic eoi);
		token_t tok;
		aet_pkg::kind_t k;
		logic [63:0] grown;
		tok = '0;
		if (!eoi) begin
			if (b == aet_pkg::CH_LF) begin
				if (line_no != '1)
					line_no++;
				col_no = CB'(1);
			end else if (col_no != '1) begin
				col_no++;
			end
			if (b == aet_pkg::CH_SPACE || b == aet_pkg::CH_TAB || b == aet_pkg::CH_LF ||
				b == aet_pkg::CH_CR || b == aet_pkg::CH_FF)
				return;
			if (b >= aet_pkg::CH_ZERO && b <= aet_pkg::CH_NINE) begin
				grown = {32'd0, acc} * 64'd10 + {56'd0, 8'(b - aet_pkg::CH_ZERO)};
				if (!in_lit) begin
					in_lit = 1'b1;
					acc = VB'(b - aet_pkg::CH_ZERO);
					acc_ovf = 1'b0;
				end else if (acc_ovf || grown[63:32] != 0) begin
					acc = '1;
					acc_ovf = 1'b1;
				end else begin
					acc = grown[31:0];
				end
				return;
			end
		end
		tok.line = line_no;
		tok.col = col_no;
		if (in_lit) begin
			tok.kind = aet_pkg::KIND_INTLIT;
			tok.value = acc;
			tok.ovf = acc_ovf;
			tokens_due.push_back(tok);
			in_lit = 1'b0;
			acc = '0;
			acc_ovf = 1'b0;
		end
		if (eoi)
			k = aet_pkg::KIND_END;
		else
			case (b)
				aet_pkg::CH_PLUS: k = aet_pkg::KIND_ADD;
				aet_pkg::CH_MINUS: k = aet_pkg::KIND_SUB;
				aet_pkg::CH_STAR: k = aet_pkg::KIND_MULT;
				aet_pkg::CH_SLASH: k = aet_pkg::KIND_DIV;
				default: k = aet_pkg::KIND_INVALID;
			endcase
		tok.kind = k;
		tok.value = '0;
		tok.ovf = 1'b0;
		tok.is_last = 1'b1;
		tokens_due.push_back(tok);
	endfunction

	task automatic send_item(input logic [7:0] b, input logic eoi);
		int gap;
		gap = (!steady && $urandom_range(0, 2) == 0) ? idle_len() : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			ch <= 8'($urandom);
			end_of_input <= 1'($urandom);
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		ch <= b;
		end_of_input <= eoi;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		tokenize_byte(b, eoi);
		bytes_sent++;
	endtask

	// drop valid so the last byte is not taken twice, then hold until drained
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tokens_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_single_tokens();
		logic [7:0] seq [13] = '{aet_pkg::CH_PLUS, aet_pkg::CH_MINUS, aet_pkg::CH_STAR,
			aet_pkg::CH_SLASH, aet_pkg::CH_SPACE, aet_pkg::CH_TAB, aet_pkg::CH_LF,
			aet_pkg::CH_CR, aet_pkg::CH_FF, 8'h00, aet_pkg::CH_ZERO, 8'hFF,
			aet_pkg::CH_NINE + 8'd1};
		foreach (seq[i])
			send_item(seq[i], 1'b0);
		send_item(8'($urandom), 1'b1);
	endtask

	task automatic test_widest_literal();
		string digits;
		digits = "4294967295";
		for (int i = 0; i < digits.len(); i++) begin
			if (i == 5)
				send_item(aet_pkg::CH_CR, 1'b0);
			send_item(digits[i], 1'b0);
		end
		send_item(8'($urandom), 1'b1);
	endtask

	task automatic test_random_expressions();
		int stop_at;
		int len;
		stop_at = bytes_sent + 800;
		while (bytes_sent < stop_at) begin
			steady = ($urandom_range(0, 5) == 0);
			for (int t = $urandom_range(1, 6); t > 0; t--) begin
				if ($urandom_range(0, 9) == 0)
					send_item(8'($urandom), 1'b0);
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 4);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 7) == 0)
						send_item(any_space(), 1'b0);
					send_item(aet_pkg::CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
				end
				// hold mid-literal until the output has caught up
				if ($urandom_range(0, 19) == 0)
					wait_drained();
				if ($urandom_range(0, 2) == 0)
					send_item(any_space(), 1'b0);
				if (t > 1)
					send_item(any_operator(), 1'b0);
			end
			if ($urandom_range(0, 3) != 0)
				send_item(8'($urandom), 1'b1);
			else
				send_item(aet_pkg::CH_LF, 1'b0);
		end
		steady = 1'b0;
	endtask

	always @(posedge clk) begin
		if (steady) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 3) == 0) begin
			out_stall <= 1'b1;
			stall_left <= idle_len() - 1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : check_results
		token_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (tokens_due.size() == 0) begin
				$error("result with no transaction pending: token_kind %0d", token_kind);
				mismatches++;
			end else begin
				want = tokens_due.pop_front();
				check_field("token_kind", 32'(want.kind), 32'(token_kind));
				check_field("literal_value", want.value, literal_value);
				check_field("overflowed", 32'(want.ovf), 32'(overflowed));
				check_field("line_at", 32'(want.line), 32'(line_at));
				check_field("column_at", 32'(want.col), 32'(column_at));
				check_field("last", 32'(want.is_last), 32'(last));
				tokens_seen++;
				if (want.kind == aet_pkg::KIND_INTLIT)
					literals_seen++;
				if (want.ovf)
					saturated_seen++;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == HANG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_single_tokens();
		test_widest_literal();
		test_random_expressions();
		wait_drained();
		repeat (16) @(posedge clk);
		$display("Sent %0d transactions; checked %0d tokens, %0d of them literals (%0d saturated).",
			bytes_sent, tokens_seen, literals_seen, saturated_seen);
		$display("Covered every operator, whitespace, invalid bytes, end marks and long literals.");
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire
